@@ rtl/pcerm_pkg.sv @@
// ----------------------------------------------------------------------------
// pcerm_pkg
// Shared constants, register indexes and helpers of the per-class event rate
// anomaly monitor.
// ----------------------------------------------------------------------------
package pcerm_pkg;

	localparam int NUM_SLOTS = 7;
	localparam int SLOT_W = $clog2(NUM_SLOTS);

	localparam int CODE_W = 8;
	localparam int TIME_W = 48;
	localparam int CNT_W = 32;
	localparam int MULT_W = 8;
	localparam int PROD_W = 2 * CNT_W;
	localparam int LIMIT_W = CNT_W + MULT_W;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_MULT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_TIME = 2'd2;

	localparam logic [CNT_W-1:0] WINDOW_RESET = 32'd3600000;
	localparam logic [MULT_W-1:0] MULT_RESET = 8'd10;
	localparam logic [TIME_W-1:0] START_RESET = '0;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == '1) ? v : v + 1'b1;
	endfunction

endpackage

@@ rtl/pcerm_if.sv @@
// ----------------------------------------------------------------------------
// pcerm channel interfaces
// Detection input, result output and register write channels.
// ----------------------------------------------------------------------------
interface pcerm_event_if;
	logic                              valid;
	logic                              ready;
	logic [pcerm_pkg::CODE_W-1:0]      class_code;
	logic [pcerm_pkg::TIME_W-1:0]      now_ms;

	modport source (output valid, output class_code, output now_ms, input ready);
	modport sink (input valid, input class_code, input now_ms, output ready);
endinterface

interface pcerm_result_if #(
	parameter int SLOT_W = pcerm_pkg::SLOT_W
);
	logic                              valid;
	logic                              ready;
	logic [SLOT_W-1:0]                 slot_index;
	logic                              anomalous;
	logic [pcerm_pkg::CNT_W-1:0]       total_count;
	logic [pcerm_pkg::CNT_W-1:0]       window_count;
	logic [pcerm_pkg::CNT_W-1:0]       baseline_rate;

	modport source (output valid, output slot_index, output anomalous, output total_count,
		output window_count, output baseline_rate, input ready);
	modport sink (input valid, input slot_index, input anomalous, input total_count,
		input window_count, input baseline_rate, output ready);
endinterface

interface pcerm_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [pcerm_pkg::CFG_IDX_W-1:0]   index;
	logic [pcerm_pkg::TIME_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/pcerm_div.sv @@
// ----------------------------------------------------------------------------
// pcerm_div
// Bit-serial restoring divider: one quotient bit per cycle, the dividend
// shifting out of the top of the register while quotient bits shift in.
// ----------------------------------------------------------------------------
module pcerm_div #(
	parameter int NUM_W = pcerm_pkg::PROD_W,
	parameter int DEN_W = pcerm_pkg::TIME_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int CntW = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CntW-1:0]  cnt_q;
	logic [NUM_W-1:0] dq_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             qbit;

	// partial remainder stays below the divisor, so one extra bit suffices
	assign trial = {rem_q, dq_q[NUM_W-1]};
	assign diff = trial - {1'b0, den_q};
	assign qbit = !diff[DEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			dq_q <= {dq_q[NUM_W-2:0], qbit};
			rem_q <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quotient = dq_q;

endmodule

@@ rtl/per_class_event_rate_anomaly_monitor.sv @@
// ----------------------------------------------------------------------------
// per_class_event_rate_anomaly_monitor
// Counts detection events per class slot, rolls the window into a baseline and
// flags a slot whose scaled current rate exceeds baseline times multiplier.
// ----------------------------------------------------------------------------
// one event at a time: a detection is taken only in the idle state and then
// passes the update, multiply, 64-step bit-serial divide and output states;
// a new event is taken while the previous result still waits in its register
// reset: counters and baselines clear, window starts load zero, registers
// take their defaults (window 3600000 ms, multiplier 10, start time 0)
module per_class_event_rate_anomaly_monitor #(
	parameter int NUM_SLOTS = pcerm_pkg::NUM_SLOTS
) (
	input  logic          clk,
	input  logic          arst_n,
	pcerm_event_if.sink   det,
	pcerm_result_if.source res,
	pcerm_cfg_if.sink     cfg
);

	localparam int SlotW = $clog2(NUM_SLOTS);
	localparam int CntW = pcerm_pkg::CNT_W;
	localparam int TimeW = pcerm_pkg::TIME_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD = 3'd1;
	localparam logic [2:0] ST_MUL = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	logic [2:0] state_q;

	logic [CntW-1:0]                window_len_q;
	logic [pcerm_pkg::MULT_W-1:0]   mult_q;

	logic [CntW-1:0]  total_q [NUM_SLOTS];
	logic [CntW-1:0]  wcount_q [NUM_SLOTS];
	logic [CntW-1:0]  base_arr_q [NUM_SLOTS];
	logic [TimeW-1:0] wstart_q [NUM_SLOTS];

	logic [SlotW-1:0] slot_q;
	logic [TimeW-1:0] now_q;
	logic [CntW-1:0]  tot_q;
	logic [CntW-1:0]  wc_q;
	logic [CntW-1:0]  base_q;
	logic [TimeW-1:0] elapsed_q;
	logic [pcerm_pkg::LIMIT_W-1:0] limit_q;
	logic             cond_q;

	logic             out_valid_q;
	logic [SlotW-1:0] out_slot_q;
	logic             out_flag_q;
	logic [CntW-1:0]  out_tot_q;
	logic [CntW-1:0]  out_wc_q;
	logic [CntW-1:0]  out_base_q;

	logic [SlotW-1:0] sel_slot;
	logic [CntW-1:0]  tot_inc;
	logic [CntW-1:0]  wc_inc;
	logic [TimeW-1:0] elapsed;
	logic             roll;
	logic [pcerm_pkg::PROD_W-1:0]  prod;
	logic [pcerm_pkg::LIMIT_W-1:0] limit;
	logic             div_done;
	logic [pcerm_pkg::PROD_W-1:0]  quot;
	logic             flag;
	logic             det_xfer;
	logic             out_load;

	assign det.ready = (state_q == ST_IDLE);
	assign det_xfer = det.valid && det.ready;
	assign cfg.ready = 1'b1;

	// class codes past the own slots share the last slot
	assign sel_slot = (det.class_code < pcerm_pkg::CODE_W'(NUM_SLOTS - 1)) ?
		det.class_code[SlotW-1:0] : SlotW'(NUM_SLOTS - 1);

	assign tot_inc = pcerm_pkg::sat_inc(total_q[slot_q]);
	assign wc_inc = pcerm_pkg::sat_inc(wcount_q[slot_q]);
	assign elapsed = now_q - wstart_q[slot_q];
	assign roll = (elapsed >= {{(TimeW - CntW){1'b0}}, window_len_q});

	assign prod = pcerm_pkg::PROD_W'(wc_q) * pcerm_pkg::PROD_W'(window_len_q);
	assign limit = pcerm_pkg::LIMIT_W'(base_q) * pcerm_pkg::LIMIT_W'(mult_q);

	pcerm_div #(
		.NUM_W (pcerm_pkg::PROD_W),
		.DEN_W (TimeW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_MUL),
		.dividend (prod),
		.divisor  (elapsed_q),
		.done     (div_done),
		.quotient (quot)
	);

	assign flag = cond_q &&
		(quot > {{(pcerm_pkg::PROD_W - pcerm_pkg::LIMIT_W){1'b0}}, limit_q});
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (det_xfer) state_q <= ST_UPD;
				end
				ST_UPD: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// slot state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= pcerm_pkg::WINDOW_RESET;
			mult_q <= pcerm_pkg::MULT_RESET;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				total_q[i] <= '0;
				wcount_q[i] <= '0;
				base_arr_q[i] <= '0;
				wstart_q[i] <= pcerm_pkg::START_RESET;
			end
		end else begin
			if (state_q == ST_UPD) begin
				total_q[slot_q] <= tot_inc;
				if (roll) begin
					base_arr_q[slot_q] <= wc_inc;
					wcount_q[slot_q] <= '0;
					wstart_q[slot_q] <= now_q;
				end else begin
					wcount_q[slot_q] <= wc_inc;
				end
			end
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					pcerm_pkg::CFG_WINDOW_LENGTH: window_len_q <= cfg.data[CntW-1:0];
					pcerm_pkg::CFG_THRESHOLD_MULT: mult_q <= cfg.data[pcerm_pkg::MULT_W-1:0];
					pcerm_pkg::CFG_START_TIME: begin
						for (int i = 0; i < NUM_SLOTS; i++) wstart_q[i] <= cfg.data;
					end
					default: ;
				endcase
			end
		end
	end

	// per-event working registers
	always_ff @(posedge clk) begin
		if (det_xfer) begin
			slot_q <= sel_slot;
			now_q <= det.now_ms;
		end
		if (state_q == ST_UPD) begin
			tot_q <= tot_inc;
			wc_q <= roll ? '0 : wc_inc;
			base_q <= roll ? wc_inc : base_arr_q[slot_q];
			elapsed_q <= roll ? '0 : elapsed;
		end
		if (state_q == ST_MUL) begin
			limit_q <= limit;
			cond_q <= (base_q != '0) && (elapsed_q != '0);
		end
		if (out_load) begin
			out_slot_q <= slot_q;
			out_flag_q <= flag;
			out_tot_q <= tot_q;
			out_wc_q <= wc_q;
			out_base_q <= base_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res.valid = out_valid_q;
	assign res.slot_index = out_slot_q;
	assign res.anomalous = out_flag_q;
	assign res.total_count = out_tot_q;
	assign res.window_count = out_wc_q;
	assign res.baseline_rate = out_base_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide phase");

	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> slot_q <= SlotW'(NUM_SLOTS - 1))
		else $error("working slot beyond the last slot");

	a_flag_needs_counts: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.anomalous |-> res.baseline_rate != '0 && res.window_count != '0)
		else $error("anomaly flagged with empty baseline or window");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the per-class event rate anomaly monitor. A local
// rate model tracks every slot's counters, window start and baseline. It
// scores each detection transfer and queues the result expected from it. A
// monitor compares every result transfer against the oldest entry. Traffic
// covers slot mapping, window roll-over, out-of-range register values, a
// long receiver hold-off and randomized bursty timelines under random stalls.
// ----------------------------------------------------------------------------
module testbench;

	localparam int NUM_SLOTS = pcerm_pkg::NUM_SLOTS;
	localparam int SLOT_W = pcerm_pkg::SLOT_W;
	localparam int CODE_W = pcerm_pkg::CODE_W;
	localparam int TIME_W = pcerm_pkg::TIME_W;
	localparam int CNT_W = pcerm_pkg::CNT_W;
	localparam int MULT_W = pcerm_pkg::MULT_W;
	localparam int PROD_W = pcerm_pkg::PROD_W;
	localparam int CFG_IDX_W = pcerm_pkg::CFG_IDX_W;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int UNKNOWN_SLOT = NUM_SLOTS - 1;
	// the limit covers event processing, sender gaps, receiver stalls and the long hold-off
	localparam int STALL_LIMIT = 5000;
	localparam int TAIL_CYCLES = 100;
	localparam int HOLD_CYCLES = 700;

	typedef struct packed {
		logic [SLOT_W-1:0] slot_index;
		logic              anomalous;
		logic [CNT_W-1:0]  total_count;
		logic [CNT_W-1:0]  window_count;
		logic [CNT_W-1:0]  baseline_rate;
	} slot_report_t;

	logic clk;
	logic arst_n;

	pcerm_event_if  det_if ();
	pcerm_result_if res_if ();
	pcerm_cfg_if    cfg_if ();

	per_class_event_rate_anomaly_monitor dut (
		.clk    (clk),
		.arst_n (arst_n),
		.det    (det_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	// rate model state
	logic [CNT_W-1:0]  cur_window_len;
	logic [MULT_W-1:0] cur_mult;
	logic [TIME_W-1:0] cur_start;
	logic [CNT_W-1:0]  tally_total [NUM_SLOTS];
	logic [CNT_W-1:0]  tally_window [NUM_SLOTS];
	logic [CNT_W-1:0]  tally_base [NUM_SLOTS];
	logic [TIME_W-1:0] win_start [NUM_SLOTS];

	slot_report_t pending_results[$];

	int errors = 0;
	int events_sent = 0;
	int results_checked = 0;
	int flagged_seen = 0;
	int reg_writes = 0;
	int idle_cycles = 0;
	int hold_len = 0;
	bit gaps_on = 1'b1;
	bit stall_on = 1'b1;
	bit burst = 1'b0;
	logic [TIME_W-1:0] stamp = '0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void load_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [TIME_W-1:0] data);
		case (idx)
		pcerm_pkg::CFG_WINDOW_LENGTH: cur_window_len = data[CNT_W-1:0];
		pcerm_pkg::CFG_THRESHOLD_MULT: cur_mult = data[MULT_W-1:0];
		pcerm_pkg::CFG_START_TIME: begin
			cur_start = data;
			for (int i = 0; i < NUM_SLOTS; i++)
				win_start[i] = data;
		end
		default: ;
		endcase
	endfunction

	function automatic slot_report_t score_event(input logic [CODE_W-1:0] code,
		input logic [TIME_W-1:0] now);
		int s;
		logic [TIME_W-1:0] elapsed;
		logic [PROD_W-1:0] rate;
		logic [PROD_W-1:0] ceiling;
		slot_report_t r;
		s = (code < UNKNOWN_SLOT) ? int'(code) : UNKNOWN_SLOT;
		if (tally_total[s] != '1)
			tally_total[s] = tally_total[s] + 1'b1;
		if (tally_window[s] != '1)
			tally_window[s] = tally_window[s] + 1'b1;
		// modular 48-bit difference, an earlier stamp reads as a huge gap
		elapsed = now - win_start[s];
		if (elapsed >= TIME_W'(cur_window_len)) begin
			tally_base[s] = tally_window[s];
			win_start[s] = now;
			tally_window[s] = '0;
			elapsed = '0;
		end
		r.anomalous = 1'b0;
		if (tally_base[s] != '0 && elapsed != '0) begin
			rate = (PROD_W'(tally_window[s]) * PROD_W'(cur_window_len)) / PROD_W'(elapsed);
			ceiling = PROD_W'(tally_base[s]) * PROD_W'(cur_mult);
			r.anomalous = rate > ceiling;
		end
		r.slot_index = SLOT_W'(s);
		r.total_count = tally_total[s];
		r.window_count = tally_window[s];
		r.baseline_rate = tally_base[s];
		return r;
	endfunction

	task automatic send_event(input logic [CODE_W-1:0] code, input logic [TIME_W-1:0] now);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			det_if.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		det_if.valid <= 1'b1;
		det_if.class_code <= code;
		det_if.now_ms <= now;
		do @(posedge clk); while (!det_if.ready);
		pending_results = {pending_results, score_event(code, now)};
		events_sent++;
	endtask

	// registers change only with the block drained
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
		det_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		do @(posedge clk); while (!cfg_if.ready);
		load_register(idx, data);
		reg_writes++;
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// shared timeline alternating sparse and bursty spacing, with some noise
	task automatic random_event();
		logic [CODE_W-1:0] code;
		logic [TIME_W-1:0] now;
		logic [CNT_W-1:0] span;
		span = (cur_window_len == '0) ? 1 : cur_window_len;
		if ($urandom_range(0, 19) == 0)
			burst = !burst;
		if ($urandom_range(0, 99) < 6) begin
			code = CODE_W'($urandom);
			now = {16'($urandom), 32'($urandom)};
		end else begin
			if ($urandom_range(0, 9) == 0)
				code = CODE_W'($urandom);
			else
				code = CODE_W'($urandom_range(0, UNKNOWN_SLOT));
			if (burst)
				stamp = stamp + TIME_W'($urandom_range(0, span >> 4));
			else
				stamp = stamp + TIME_W'($urandom_range(span >> 1, span))
					+ TIME_W'($urandom_range(0, span));
			now = stamp;
		end
		send_event(code, now);
	endtask

	task automatic test_slot_mapping();
		logic [CODE_W-1:0] codes [10] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7,
			8'd128, 8'd255};
		foreach (codes[i])
			send_event(codes[i], TIME_W'(i));
		// all-ones stamp is far past the default window
		send_event(8'd5, '1);
	endtask

	task automatic test_window_rollover();
		write_register(pcerm_pkg::CFG_WINDOW_LENGTH, 48'd10);
		write_register(pcerm_pkg::CFG_THRESHOLD_MULT, 48'd1);
		write_register(pcerm_pkg::CFG_START_TIME, 48'd1000);
		send_event(8'd2, 48'd1010);
		send_event(8'd2, 48'd1011);
		// stamp behind the window start wraps around
		send_event(8'd2, 48'd1005);
		send_event(8'd6, 48'd1003);
	endtask

	task automatic test_out_of_range_settings();
		write_register(CFG_UNUSED, '1);
		write_register(pcerm_pkg::CFG_WINDOW_LENGTH, {16'hBEEF, 32'h0});
		write_register(pcerm_pkg::CFG_THRESHOLD_MULT, {40'hA55A5AA5A5, 8'h00});
		// zero window closes on every event
		send_event(8'd3, 48'd5);
		send_event(8'd3, 48'd5);
		write_register(pcerm_pkg::CFG_WINDOW_LENGTH, 48'd100);
		write_register(pcerm_pkg::CFG_START_TIME, 48'd0);
		send_event(8'd4, 48'd100);
		send_event(8'd4, 48'd150);
		write_register(pcerm_pkg::CFG_WINDOW_LENGTH, {16'h1234, 32'hFFFF_FFFF});
		write_register(pcerm_pkg::CFG_THRESHOLD_MULT, {40'h5AA5A55A5A, 8'hFF});
		send_event(8'd1, 48'h0000_FFFF_FFFE);
		send_event(8'd1, 48'h0001_0000_0000);
	endtask

	task automatic test_backpressure();
		gaps_on = 1'b0;
		stall_on = 1'b0;
		hold_len = HOLD_CYCLES;
		repeat (24) random_event();
	endtask

	task automatic test_random_traffic(input int phases, input int per_phase);
		logic [CNT_W-1:0] wl;
		logic [MULT_W-1:0] mult;
		logic [TIME_W-1:0] start;
		for (int p = 0; p < phases; p++) begin
			gaps_on = $urandom_range(0, 3) != 0;
			stall_on = $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 7))
			0: wl = 1;
			1: wl = 0;
			2: wl = '1;
			3: wl = $urandom;
			default: wl = $urandom_range(8, 120);
			endcase
			case ($urandom_range(0, 5))
			0: mult = '0;
			1: mult = '1;
			2: mult = MULT_W'($urandom);
			default: mult = MULT_W'($urandom_range(1, 3));
			endcase
			case ($urandom_range(0, 3))
			0: start = '1 - TIME_W'($urandom_range(0, 50));
			1: start = '0;
			default: start = {16'($urandom), 32'($urandom)};
			endcase
			write_register(pcerm_pkg::CFG_WINDOW_LENGTH, {16'($urandom), wl});
			write_register(pcerm_pkg::CFG_THRESHOLD_MULT, {32'($urandom), 8'($urandom), mult});
			if ($urandom_range(0, 1) == 1) begin
				write_register(pcerm_pkg::CFG_START_TIME, start);
				stamp = start;
			end
			repeat (per_phase) random_event();
		end
	endtask

	task automatic test_quiet_tail();
		gaps_on = 1'b0;
		stall_on = 1'b0;
		repeat (100) random_event();
	endtask

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		int n;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				n = hold_len;
				hold_len = 0;
				res_if.ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else if (stall_on && $urandom_range(0, 6) == 0) begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(0, 12)) @(posedge clk);
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		slot_report_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected: slot %0d", res_if.slot_index);
				errors++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (res_if.anomalous === 1'b1)
					flagged_seen++;
				if (res_if.slot_index !== want.slot_index) begin
					$error("slot_index: expected %0d, got %0d", want.slot_index, res_if.slot_index);
					errors++;
				end
				if (res_if.anomalous !== want.anomalous) begin
					$error("anomalous: expected %0d, got %0d", want.anomalous, res_if.anomalous);
					errors++;
				end
				if (res_if.total_count !== want.total_count) begin
					$error("total_count: expected %0d, got %0d", want.total_count,
						res_if.total_count);
					errors++;
				end
				if (res_if.window_count !== want.window_count) begin
					$error("window_count: expected %0d, got %0d", want.window_count,
						res_if.window_count);
					errors++;
				end
				if (res_if.baseline_rate !== want.baseline_rate) begin
					$error("baseline_rate: expected %0d, got %0d", want.baseline_rate,
						res_if.baseline_rate);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((det_if.valid && det_if.ready) || (res_if.valid && res_if.ready)
			|| (cfg_if.valid && cfg_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$error("no transfer for %0d cycles, %0d results outstanding", idle_cycles,
				pending_results.size());
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n <= 1'b0;
		det_if.valid <= 1'b0;
		det_if.class_code <= '0;
		det_if.now_ms <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= '0;
		cfg_if.data <= '0;
		cur_window_len = pcerm_pkg::WINDOW_RESET;
		cur_mult = pcerm_pkg::MULT_RESET;
		cur_start = pcerm_pkg::START_RESET;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			tally_total[i] = '0;
			tally_window[i] = '0;
			tally_base[i] = '0;
			win_start[i] = pcerm_pkg::START_RESET;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_slot_mapping();
		test_window_rollover();
		test_out_of_range_settings();
		test_backpressure();
		test_random_traffic(11, 110);
		test_quiet_tail();

		det_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d detection events scored, %0d results checked, %0d register writes",
			events_sent, results_checked, reg_writes);
		$display("%0d results flagged anomalous, %0d mismatches", flagged_seen, errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
